@@ src/neighbourhood_min_sum_check_update_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the neighbourhood min-sum check update block
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOURHOOD_MIN_SUM_CHECK_UPDATE_TOP_DEFINES_SVH
`define NEIGHBOURHOOD_MIN_SUM_CHECK_UPDATE_TOP_DEFINES_SVH

// same-cycle implication
`define NMSCU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define NMSCU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/nmscu_pkg.sv @@
// ----------------------------------------------------------------------------
// nmscu_pkg
// Types and constants shared by the min-sum check update block.
// ----------------------------------------------------------------------------
`default_nettype none

package nmscu_pkg;

    localparam int LLR_W   = 16;
    localparam int K_LIMIT = 8;
    localparam int SUM_W   = 19;
    localparam int DIFF_W  = SUM_W + 2;
    localparam int MSG_SAT = 32767;

    localparam logic [1:0] MODE_LOAD_AXIS  = 2'd0;
    localparam logic [1:0] MODE_LOAD_CHECK = 2'd1;
    localparam logic [1:0] MODE_COMPUTE    = 2'd2;

    localparam logic [1:0] OUT_BOTH      = 2'd0;
    localparam logic [1:0] OUT_ONE_ONLY  = 2'd1;
    localparam logic [1:0] OUT_ZERO_ONLY = 2'd2;
    localparam logic [1:0] OUT_NONE      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_LOAD,
        ST_EMIT
    } nmscu_state_t;

    typedef struct packed {
        logic               vld;
        logic               ok;
        logic [K_LIMIT-1:0] idx;
        logic [SUM_W-1:0]   sum;
    } nmscu_sweep_t;

    typedef struct packed {
        logic                    wr;
        logic [2:0]              axis;
        logic signed [LLR_W-1:0] llr;
        logic                    is_edge;
    } nmscu_axis_wr_t;

    typedef struct packed {
        logic       clear;
        logic       load;
        logic       shift;
        logic [3:0] k;
    } nmscu_cell_ctrl_t;

    typedef struct packed {
        logic               wr;
        logic               clr;
        logic               issue;
        logic [K_LIMIT-1:0] idx;
        logic [7:0]         mask;
        logic               parity;
    } nmscu_chk_ctrl_t;

    typedef struct packed {
        logic                    vld;
        logic signed [LLR_W-1:0] msg;
        logic [2:0]              axis;
        logic [1:0]              outcome;
    } nmscu_result_t;

endpackage

`default_nettype wire

@@ src/nmscu_check_unit.sv @@
// ----------------------------------------------------------------------------
// nmscu_check_unit
// Internal parity check list; marks each swept assignment as kept or dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module nmscu_check_unit #(
    parameter int MAX_INNER_CHECKS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire nmscu_pkg::nmscu_chk_ctrl_t ctrl,
    output nmscu_pkg::nmscu_sweep_t      pipe_out
);

    localparam int CNT_W = $clog2(MAX_INNER_CHECKS + 1);

    logic [CNT_W-1:0] count_reg;
    logic [7:0]       mask_reg [MAX_INNER_CHECKS];
    logic             par_reg  [MAX_INNER_CHECKS];
    logic [MAX_INNER_CHECKS-1:0] fail;
    nmscu_pkg::nmscu_sweep_t pipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.clr)
        begin
            count_reg <= '0;
        end
        else if (ctrl.wr && (count_reg != CNT_W'(MAX_INNER_CHECKS)))
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    for (genvar i = 0; i < MAX_INNER_CHECKS; i++)
    begin : g_entry
        always_ff @(posedge clk)
        begin
            if (ctrl.wr && (count_reg == CNT_W'(i)))
            begin
                mask_reg[i] <= ctrl.mask;
                par_reg[i]  <= ctrl.parity;
            end
        end

        assign fail[i] = (CNT_W'(i) < count_reg)
                         && ((^(ctrl.idx & mask_reg[i])) != par_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_reg <= '0;
        end
        else
        begin
            pipe_reg.vld <= ctrl.issue;
            pipe_reg.ok  <= ~|fail;
            pipe_reg.idx <= ctrl.idx;
            pipe_reg.sum <= '0;
        end
    end

    assign pipe_out = pipe_reg;

endmodule

`default_nettype wire

@@ src/nmscu_cell.sv @@
// ----------------------------------------------------------------------------
// nmscu_cell
// One axis: holds its prior, adds its cost to the passing assignment, tracks
// the best kept totals with the axis at zero and at one, and forms its message.
// ----------------------------------------------------------------------------
`default_nettype none

module nmscu_cell #(
    parameter int IDX = 0
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire nmscu_pkg::nmscu_axis_wr_t  ld,
    input  wire nmscu_pkg::nmscu_cell_ctrl_t ctrl,
    input  wire nmscu_pkg::nmscu_sweep_t    pipe_in,
    input  wire nmscu_pkg::nmscu_sweep_t    tail,
    input  wire nmscu_pkg::nmscu_result_t   res_in,
    output nmscu_pkg::nmscu_sweep_t         pipe_out,
    output nmscu_pkg::nmscu_result_t        res_out
);

    localparam int SUM_W  = nmscu_pkg::SUM_W;
    localparam int DIFF_W = nmscu_pkg::DIFF_W;
    localparam int LLR_W  = nmscu_pkg::LLR_W;
    localparam logic signed [DIFF_W-1:0] SAT_HI = DIFF_W'(nmscu_pkg::MSG_SAT);
    localparam logic signed [DIFF_W-1:0] SAT_LO = -SAT_HI;

    logic signed [LLR_W-1:0] llr_reg;
    logic                    edge_reg;
    logic                    have0_reg;
    logic                    have1_reg;
    logic [SUM_W-1:0]        min0_reg;
    logic [SUM_W-1:0]        min1_reg;
    nmscu_pkg::nmscu_sweep_t  pipe_reg;
    nmscu_pkg::nmscu_sweep_t  pipe_next;
    nmscu_pkg::nmscu_result_t res_reg;
    nmscu_pkg::nmscu_result_t res_next;

    logic                    active;
    logic [LLR_W:0]          neg_mag;
    logic [SUM_W-1:0]        cost;
    logic                    tbit;
    logic signed [DIFF_W-1:0] diff;

    assign active  = (4'(IDX) < ctrl.k);
    assign neg_mag = ~{llr_reg[LLR_W-1], llr_reg} + 1'b1;
    assign tbit    = tail.idx[IDX];

    always_comb
    begin
        if (pipe_in.idx[IDX])
        begin
            cost = llr_reg[LLR_W-1] ? '0 : {{(SUM_W-LLR_W){1'b0}}, llr_reg};
        end
        else
        begin
            cost = llr_reg[LLR_W-1] ? {{(SUM_W-LLR_W-1){1'b0}}, neg_mag} : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg <= 1'b0;
        end
        else if (ld.wr && (ld.axis == 3'(IDX)))
        begin
            edge_reg <= ld.is_edge;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.wr && (ld.axis == 3'(IDX)))
        begin
            llr_reg <= ld.llr;
        end
    end

    always_comb
    begin
        pipe_next     = pipe_in;
        pipe_next.sum = pipe_in.sum + (active ? cost : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_reg <= '0;
        end
        else
        begin
            pipe_reg <= pipe_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have0_reg <= 1'b0;
            have1_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            have0_reg <= 1'b0;
            have1_reg <= 1'b0;
        end
        else if (tail.vld && tail.ok)
        begin
            if (!tbit && (!have0_reg || (tail.sum < min0_reg)))
            begin
                have0_reg <= 1'b1;
            end
            if (tbit && (!have1_reg || (tail.sum < min1_reg)))
            begin
                have1_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.vld && tail.ok)
        begin
            if (!tbit && (!have0_reg || (tail.sum < min0_reg)))
            begin
                min0_reg <= tail.sum;
            end
            if (tbit && (!have1_reg || (tail.sum < min1_reg)))
            begin
                min1_reg <= tail.sum;
            end
        end
    end

    assign diff = $signed({2'b00, min1_reg}) - $signed({2'b00, min0_reg})
                  - $signed({{(DIFF_W-LLR_W){llr_reg[LLR_W-1]}}, llr_reg});

    always_comb
    begin
        res_next = res_reg;
        if (ctrl.load)
        begin
            res_next.vld  = edge_reg && active;
            res_next.axis = 3'(IDX);
            priority if (have0_reg && have1_reg)
            begin
                res_next.outcome = nmscu_pkg::OUT_BOTH;
                if (diff > SAT_HI)
                begin
                    res_next.msg = LLR_W'(SAT_HI);
                end
                else if (diff < SAT_LO)
                begin
                    res_next.msg = LLR_W'(SAT_LO);
                end
                else
                begin
                    res_next.msg = diff[LLR_W-1:0];
                end
            end
            else if (have1_reg)
            begin
                res_next.outcome = nmscu_pkg::OUT_ONE_ONLY;
                res_next.msg     = LLR_W'(SAT_LO);
            end
            else if (have0_reg)
            begin
                res_next.outcome = nmscu_pkg::OUT_ZERO_ONLY;
                res_next.msg     = LLR_W'(SAT_HI);
            end
            else
            begin
                res_next.outcome = nmscu_pkg::OUT_NONE;
                res_next.msg     = '0;
            end
        end
        else if (ctrl.shift)
        begin
            res_next = res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign pipe_out = pipe_reg;
    assign res_out  = res_reg;

endmodule

`default_nettype wire

@@ src/neighbourhood_min_sum_check_update_top.sv @@
// ----------------------------------------------------------------------------
// neighbourhood_min_sum_check_update_top
// Min-sum check update over one neighbourhood of up to eight binary axes.
// ----------------------------------------------------------------------------
// Load items store an axis prior or an internal check. A compute item sweeps
// all 2^K assignments, one per cycle, through a row of axis cells in which
// each of the first K adds its own cost; the totals that pass the internal
// checks update every cell's minima. The cells then form their messages,
// which shift out through the cell row towards the output register. Input
// is not taken while a compute item is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbourhood_min_sum_check_update_top #(
    parameter int MAX_AXIS_COUNT   = 8,
    parameter int MAX_INNER_CHECKS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // axis_index[2:0], axis_llr[18:3], axis_is_edge[19], check_mask[27:20],
    // syndrome_bit[28], axis_count[32:29], zero[39:33]
    input  wire logic [39:0] s_tdata,
    // mode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // message[15:0], out_axis[18:16], outcome[20:19], zero[23:21]
    output logic [23:0]      m_tdata,
    output logic             m_tlast
);

    localparam int AXES  = (MAX_AXIS_COUNT < nmscu_pkg::K_LIMIT) ?
                           MAX_AXIS_COUNT : nmscu_pkg::K_LIMIT;
    localparam int DCN_W = $clog2(AXES + 1);

    nmscu_pkg::nmscu_state_t state_reg, state_next;
    logic [AXES-1:0]  idx_reg,  idx_next;
    logic [3:0]       k_reg,    k_next;
    logic [DCN_W-1:0] dcnt_reg, dcnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [23:0]      m_tdata_reg;
    logic             m_tlast_reg;

    nmscu_pkg::nmscu_sweep_t     pipe [AXES+1];
    nmscu_pkg::nmscu_result_t    res  [AXES+1];
    nmscu_pkg::nmscu_chk_ctrl_t  chk_ctrl;
    nmscu_pkg::nmscu_axis_wr_t   ld;
    nmscu_pkg::nmscu_cell_ctrl_t cell_ctrl;

    logic            accept;
    logic [AXES:0]   total_m1;
    logic [3:0]      k_in;
    logic [AXES-1:0] res_vld;
    logic            later_vld;
    logic            out_free;
    logic            out_take;

    assign accept   = s_tvalid && s_tready;
    assign total_m1 = ({{AXES{1'b0}}, 1'b1} << k_reg) - 1'b1;
    assign k_in     = (s_tdata[32:29] > 4'(AXES)) ? 4'(AXES) : s_tdata[32:29];
    assign out_free = !m_tvalid_reg || m_tready;

    for (genvar j = 0; j < AXES; j++)
    begin : g_vld
        assign res_vld[j] = res[j].vld;
    end
    assign later_vld = |(res_vld >> 1);
    assign res[AXES] = '0;

    assign ld.wr      = accept && (s_tuser == nmscu_pkg::MODE_LOAD_AXIS);
    assign ld.axis    = s_tdata[2:0];
    assign ld.llr     = s_tdata[18:3];
    assign ld.is_edge = s_tdata[19];

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        dcnt_next       = dcnt_reg;
        s_tready        = 1'b0;
        out_take        = 1'b0;
        chk_ctrl.wr     = 1'b0;
        chk_ctrl.clr    = 1'b0;
        chk_ctrl.issue  = 1'b0;
        chk_ctrl.idx    = nmscu_pkg::K_LIMIT'(idx_reg);
        chk_ctrl.mask   = s_tdata[27:20];
        chk_ctrl.parity = s_tdata[28];
        cell_ctrl.clear = 1'b0;
        cell_ctrl.load  = 1'b0;
        cell_ctrl.shift = 1'b0;
        cell_ctrl.k     = k_reg;
        unique case (state_reg)
            nmscu_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                chk_ctrl.wr = s_tvalid && (s_tuser == nmscu_pkg::MODE_LOAD_CHECK);
                if (s_tvalid && (s_tuser == nmscu_pkg::MODE_COMPUTE))
                begin
                    cell_ctrl.clear = 1'b1;
                    idx_next        = '0;
                    k_next          = k_in;
                    state_next      = nmscu_pkg::ST_SWEEP;
                end
            end
            nmscu_pkg::ST_SWEEP:
            begin
                chk_ctrl.issue = 1'b1;
                if (idx_reg == total_m1[AXES-1:0])
                begin
                    dcnt_next  = '0;
                    state_next = nmscu_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            nmscu_pkg::ST_DRAIN:
            begin
                if (dcnt_reg == DCN_W'(AXES))
                begin
                    state_next = nmscu_pkg::ST_LOAD;
                end
                else
                begin
                    dcnt_next = dcnt_reg + 1'b1;
                end
            end
            nmscu_pkg::ST_LOAD:
            begin
                cell_ctrl.load = 1'b1;
                chk_ctrl.clr   = 1'b1;
                state_next     = nmscu_pkg::ST_EMIT;
            end
            nmscu_pkg::ST_EMIT:
            begin
                out_take        = res[0].vld && out_free;
                cell_ctrl.shift = res[0].vld ? out_free : 1'b1;
                if (!(|res_vld))
                begin
                    state_next = nmscu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nmscu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nmscu_pkg::ST_IDLE;
            idx_reg   <= '0;
            k_reg     <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    nmscu_check_unit #(
        .MAX_INNER_CHECKS (MAX_INNER_CHECKS)
    ) u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (chk_ctrl),
        .pipe_out (pipe[0])
    );

    for (genvar j = 0; j < AXES; j++)
    begin : g_cell
        nmscu_cell #(
            .IDX (j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ld       (ld),
            .ctrl     (cell_ctrl),
            .pipe_in  (pipe[j]),
            .tail     (pipe[AXES]),
            .res_in   (res[j+1]),
            .pipe_out (pipe[j+1]),
            .res_out  (res[j])
        );
    end

    assign m_tvalid_next = out_take ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            m_tdata_reg <= {3'b000, res[0].outcome, res[0].axis, res[0].msg};
            m_tlast_reg <= !later_vld;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

@@ src/nmscu_checker.sv @@
// ----------------------------------------------------------------------------
// nmscu_checker
// Port-level checks on the min-sum check update block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "neighbourhood_min_sum_check_update_top_defines.svh"

module nmscu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    `NMSCU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    `NMSCU_ASSERT_NOW(a_outcome_msg, m_tvalid,
        (m_tdata[15:0] != 16'h8000)
        && ((m_tdata[20:19] != nmscu_pkg::OUT_ONE_ONLY) || (m_tdata[15:0] == 16'h8001))
        && ((m_tdata[20:19] != nmscu_pkg::OUT_ZERO_ONLY) || (m_tdata[15:0] == 16'h7fff))
        && ((m_tdata[20:19] != nmscu_pkg::OUT_NONE) || (m_tdata[15:0] == 16'h0000)))

    `NMSCU_ASSERT_NEXT(a_busy_after_compute,
        s_tvalid && s_tready && (s_tuser == nmscu_pkg::MODE_COMPUTE), !s_tready)

endmodule

bind neighbourhood_min_sum_check_update_top nmscu_checker u_nmscu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
